FILE: rtl/core/mscr_pkg.sv
// ----------------------------------------------------------------------------
// mscr_pkg: shared types and constants of the multi-stop color ramp
// Field widths, the seven color stops and the phase span of the strip.
// ----------------------------------------------------------------------------
package mscr_pkg;

  localparam int COL_W   = 10;   // column index width
  localparam int WID_W   = 11;   // strip width register width
  localparam int NUM_W   = 21;   // column * span product
  localparam int PHASE_W = 11;   // quotient, 0..1530
  localparam int SEG_W   = 3;
  localparam int MIX_W   = 8;
  localparam int LVL_W   = 6;
  localparam int SUM_W   = 14;   // a*(255-mix)+b*mix, at most 16065

  localparam int unsigned STOP_COUNT = 7;
  localparam int unsigned MIX_FULL   = 255;
  localparam int unsigned SPAN       = (STOP_COUNT - 1) * MIX_FULL;
  localparam int unsigned LAST_SEG   = STOP_COUNT - 2;

  typedef logic [LVL_W-1:0] level_t;

  typedef struct packed {
    level_t red;
    level_t green;
    level_t blue;
  } rgb_t;

  localparam rgb_t STOP_0 = '{red: 6'd63, green: 6'd0,  blue: 6'd0};
  localparam rgb_t STOP_1 = '{red: 6'd63, green: 6'd32, blue: 6'd0};
  localparam rgb_t STOP_2 = '{red: 6'd63, green: 6'd63, blue: 6'd0};
  localparam rgb_t STOP_3 = '{red: 6'd0,  green: 6'd63, blue: 6'd0};
  localparam rgb_t STOP_4 = '{red: 6'd0,  green: 6'd63, blue: 6'd63};
  localparam rgb_t STOP_5 = '{red: 6'd0,  green: 6'd0,  blue: 6'd63};
  localparam rgb_t STOP_6 = '{red: 6'd44, green: 6'd0,  blue: 6'd63};

  function automatic rgb_t stop_color(input logic [SEG_W-1:0] idx);
    rgb_t c;
    unique case (idx)
      3'd0:    c = STOP_0;
      3'd1:    c = STOP_1;
      3'd2:    c = STOP_2;
      3'd3:    c = STOP_3;
      3'd4:    c = STOP_4;
      3'd5:    c = STOP_5;
      3'd6:    c = STOP_6;
      default: c = STOP_0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/mscr_div.sv
// ----------------------------------------------------------------------------
// mscr_div: pipelined restoring divider
// One quotient bit per register stage, most significant bit first.
// ----------------------------------------------------------------------------
module mscr_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mscr_pkg::NUM_W-1:0]         in_num,
  input  logic [mscr_pkg::WID_W-1:0]         in_den,
  input  logic                               in_tag,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mscr_pkg::PHASE_W-1:0]       out_quot,
  output logic                               out_tag
);

  localparam int QW    = mscr_pkg::PHASE_W;
  localparam int NW    = mscr_pkg::NUM_W;
  localparam int DW    = mscr_pkg::WID_W;
  localparam int CMP_W = NW + 1;

  logic [QW-1:0] vld;
  logic [QW:0]   en;
  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [QW-1:0] tag_r;

  assign en[QW] = !out_stall;

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int K = QW - 1 - g;

    logic [NW-1:0]    src_rem;
    logic [DW-1:0]    src_den;
    logic [QW-1:0]    src_quo;
    logic             src_v;
    logic             src_tag;
    logic [CMP_W-1:0] shifted;
    logic             take;

    if (g == 0) begin : g_first
      assign src_rem = in_num;
      assign src_den = in_den;
      assign src_quo = '0;
      assign src_v   = in_valid;
      assign src_tag = in_tag;
    end else begin : g_next
      assign src_rem = rem_r[g-1];
      assign src_den = den_r[g-1];
      assign src_quo = quo_r[g-1];
      assign src_v   = vld[g-1];
      assign src_tag = tag_r[g-1];
    end

    assign en[g]   = !vld[g] || en[g+1];
    assign shifted = CMP_W'(src_den) << K;
    assign take    = CMP_W'(src_rem) >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en[g]) begin
        vld[g] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        rem_r[g] <= take ? NW'(CMP_W'(src_rem) - shifted) : src_rem;
        den_r[g] <= src_den;
        quo_r[g] <= src_quo | (QW'(take) << K);
        tag_r[g] <= src_tag;
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[QW-1];
  assign out_quot  = quo_r[QW-1];
  assign out_tag   = tag_r[QW-1];

  // A finished division leaves a remainder below the divisor.
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (vld[QW-1] && den_r[QW-1] != '0) |-> (rem_r[QW-1] < NW'(den_r[QW-1])))
    else $error("divider remainder not below divisor");

  // The input is held off only when the first stage holds an item.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> vld[0])
    else $error("divider stalls with an empty first stage");

endmodule

FILE: rtl/core/mscr_blend.sv
// ----------------------------------------------------------------------------
// mscr_blend: segment split and color interpolation
// Splits the phase into segment and mix, blends the two bounding stops and
// divides each channel by 255, over three register stages.
// ----------------------------------------------------------------------------
module mscr_blend (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mscr_pkg::PHASE_W-1:0]  in_phase,
  input  logic                          in_single,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mscr_pkg::rgb_t                out_color
);

  localparam int PW = mscr_pkg::PHASE_W;
  localparam int SW = mscr_pkg::SUM_W;
  localparam int MW = mscr_pkg::MIX_W;

  function automatic logic [SW-1:0] mix_sum(input mscr_pkg::level_t a,
                                            input mscr_pkg::level_t b,
                                            input logic [MW-1:0] mix);
    logic [SW-1:0] inv;
    inv = SW'(mscr_pkg::MIX_FULL) - SW'(mix);
    return SW'(SW'(a) * inv) + SW'(SW'(b) * SW'(mix));
  endfunction

  function automatic mscr_pkg::level_t div255(input logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = s + (s >> 8) + SW'(1);
    return t[SW-1:8];
  endfunction

  logic                          v0, v1, v2;
  logic                          en0, en1, en2;
  logic [mscr_pkg::SEG_W-1:0]    seg0;
  logic [MW-1:0]                 mix0;
  logic [SW-1:0]                 sum_r1, sum_g1, sum_b1;
  mscr_pkg::rgb_t                color2;

  logic [mscr_pkg::SEG_W-1:0]    seg_next;
  logic [MW-1:0]                 mix_next;
  mscr_pkg::rgb_t                lo_stop, hi_stop;

  assign en2      = !v2 || !out_stall;
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign in_stall = !en0;

  // Segment is the count of full 255-steps; the strip end clamps to the last
  // segment with a full mix; a single-column item gets segment 0, mix 0.
  always_comb begin
    seg_next = '0;
    mix_next = '0;
    if (in_single) begin
      seg_next = '0;
      mix_next = '0;
    end else if (in_phase >= PW'(mscr_pkg::SPAN)) begin
      seg_next = mscr_pkg::SEG_W'(mscr_pkg::LAST_SEG);
      mix_next = MW'(mscr_pkg::MIX_FULL);
    end else begin
      for (int j = 1; j <= int'(mscr_pkg::LAST_SEG); j++) begin
        if (in_phase >= PW'(j * int'(mscr_pkg::MIX_FULL))) begin
          seg_next = mscr_pkg::SEG_W'(j);
        end
      end
      mix_next = MW'(in_phase - PW'(PW'(seg_next) * PW'(mscr_pkg::MIX_FULL)));
    end
  end

  assign lo_stop = mscr_pkg::stop_color(seg0);
  assign hi_stop = mscr_pkg::stop_color(seg0 + mscr_pkg::SEG_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en0) begin
        v0 <= in_valid;
      end
      if (en1) begin
        v1 <= v0;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      seg0 <= seg_next;
      mix0 <= mix_next;
    end
    if (en1) begin
      sum_r1 <= mix_sum(lo_stop.red,   hi_stop.red,   mix0);
      sum_g1 <= mix_sum(lo_stop.green, hi_stop.green, mix0);
      sum_b1 <= mix_sum(lo_stop.blue,  hi_stop.blue,  mix0);
    end
    if (en2) begin
      color2.red   <= div255(sum_r1);
      color2.green <= div255(sum_g1);
      color2.blue  <= div255(sum_b1);
    end
  end

  assign out_valid = v2;
  assign out_color = color2;

  // The segment never passes the last pair of stops.
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    v0 |-> (seg0 <= mscr_pkg::SEG_W'(mscr_pkg::LAST_SEG)))
    else $error("segment past the last stop pair");

  // A full mix only occurs on the clamped last segment.
  a_full_mix_last: assert property (@(posedge clk) disable iff (rst)
    (v0 && mix0 == MW'(mscr_pkg::MIX_FULL)) |->
      (seg0 == mscr_pkg::SEG_W'(mscr_pkg::LAST_SEG)))
    else $error("full mix outside the last segment");

endmodule

FILE: rtl/core/multi_stop_color_ramp.sv
// ----------------------------------------------------------------------------
// multi_stop_color_ramp: column index to RGB666 spectrum color
// Throughput is one item per cycle while the output is not stalled;
// the eleven-stage divider is fully pipelined.
// Reset (rst, synchronous) empties the pipeline and sets strip_width to 1.
// ----------------------------------------------------------------------------
//
// Pipeline overview:
//   Stage 0  clamps the width register to 1..MAX_WIDTH, clamps the column to
//            the last column of the strip, and forms the divisor width - 1.
//   Stage 1  multiplies the column by the phase span of 1530.
//   Stage 2..12 run a restoring division, one quotient bit per stage, which
//            gives the phase.
//   Stage 13..15 split the phase into segment and mix, blend the two bounding
//            stops and divide each channel by 255 into the output register.
//
// Every stage advances when it is empty or when the stage after it advances,
// so bubbles close up and a stalled output only holds the items behind it.
// The configuration register is always ready; the user must write it only
// while no item is in flight, as the block itself does not enforce this.
module multi_stop_color_ramp #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write channel for strip_width.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mscr_pkg::WID_W-1:0]    cfg_data,
  // Input item channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mscr_pkg::COL_W-1:0]    column_index,
  // Output item channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mscr_pkg::LVL_W-1:0]    red_level,
  output logic [mscr_pkg::LVL_W-1:0]    green_level,
  output logic [mscr_pkg::LVL_W-1:0]    blue_level
);

  localparam int WW = mscr_pkg::WID_W;
  localparam int CW = mscr_pkg::COL_W;
  localparam int NW = mscr_pkg::NUM_W;

  logic [WW-1:0]              strip_width;

  // Stage 0 registers.
  logic                       v0;
  logic [CW-1:0]              col0;
  logic [WW-1:0]              den0;
  logic                       single0;
  // Stage 1 registers.
  logic                       v1;
  logic [NW-1:0]              num1;
  logic [WW-1:0]              den1;
  logic                       single1;

  logic                       en0, en1;
  logic [WW-1:0]              width_eff;
  logic [WW-1:0]              den_next;
  logic [CW-1:0]              col_next;

  logic                       div_stall;
  logic                       div_valid;
  logic [mscr_pkg::PHASE_W-1:0] div_quot;
  logic                       div_single;
  logic                       blend_stall;
  mscr_pkg::rgb_t             color;

  // The register is written at any time the channel offers data.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_width <= WW'(1);
    end else if (cfg_valid && cfg_ready) begin
      strip_width <= cfg_data;
    end
  end

  // A width of zero behaves as one; a width above MAX_WIDTH saturates.
  always_comb begin
    if (strip_width == '0) begin
      width_eff = WW'(1);
    end else if (32'(strip_width) > 32'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = strip_width;
    end
    den_next = width_eff - WW'(1);
    // A column past the end of the strip reads as the last column.
    if (WW'(column_index) > den_next) begin
      col_next = CW'(den_next);
    end else begin
      col_next = column_index;
    end
  end

  assign en1      = !v1 || !div_stall;
  assign en0      = !v0 || en1;
  assign in_stall = !en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (en0) begin
        v0 <= in_valid;
      end
      if (en1) begin
        v1 <= v0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      col0    <= col_next;
      den0    <= den_next;
      single0 <= (den_next == '0);
    end
    if (en1) begin
      num1    <= NW'(NW'(col0) * NW'(mscr_pkg::SPAN));
      den1    <= den0;
      single1 <= single0;
    end
  end

  // The phase is column * 1530 / (width - 1). A single-column strip skips
  // the quotient, which is then meaningless, and uses the first stop.
  mscr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_stall  (div_stall),
    .in_num    (num1),
    .in_den    (den1),
    .in_tag    (single1),
    .out_valid (div_valid),
    .out_stall (blend_stall),
    .out_quot  (div_quot),
    .out_tag   (div_single)
  );

  mscr_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_stall  (blend_stall),
    .in_phase  (div_quot),
    .in_single (div_single),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_color (color)
  );

  assign red_level   = color.red;
  assign green_level = color.green;
  assign blue_level  = color.blue;

  // The clamped column never lies past the last column of the strip, which
  // keeps the phase within the span and the quotient within its width.
  a_col_clamped: assert property (@(posedge clk) disable iff (rst)
    v0 |-> (WW'(col0) <= den0))
    else $error("column past the strip end after clamping");

  // A single-column strip is flagged exactly when the divisor is zero.
  a_single_flag: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (single1 == (den1 == '0)))
    else $error("single-column flag disagrees with the divisor");

endmodule
